// File: hw/rtl/sph_pkg.sv
`default_nettype none

package sph_pkg;

  localparam int unsigned LastStage = 9;

  typedef logic [LastStage:1] stage_en_t;
  typedef logic signed [27:0] cross_t;

  localparam logic [2:0] SectorMax = 3'd5;

  // strip pitch in Q16 cm per eighth of a strip
  localparam logic [16:0] KU = 17'd95459;
  localparam logic [16:0] KV = 17'd87300;
  localparam logic [16:0] KW = 17'd95559;

  localparam logic [21:0] DalU  = 22'd3730576;
  localparam logic [21:0] DalVw = 22'd3734471;
  localparam logic [12:0] DalBase = 13'd2048;

  localparam logic signed [31:0] SideU     = 32'sd27475302;
  localparam logic signed [31:0] SideV     = 32'sd25100700;
  localparam logic signed [31:0] ApexX     = 32'sd12550350;
  localparam logic signed [31:0] ApexSideV = ApexX - SideV;
  localparam logic signed [31:0] TwoSideU  = 2 * SideU;
  localparam logic signed [31:0] OffY      = 32'sd3326620;
  localparam logic signed [31:0] OffZ      = 32'sd51537695;

  localparam logic signed [16:0] CosBase = 17'sd29936;
  localparam logic signed [16:0] SinBase = 17'sd58299;
  localparam logic signed [16:0] RatioVw = 17'sd59872;
  localparam logic signed [17:0] RatioUv = 18'sd71736;
  localparam logic signed [16:0] CosTilt = 17'sd59396;
  localparam logic signed [16:0] SinTilt = 17'sd27696;

  // floor division by 3 through a biased reciprocal product
  localparam logic [18:0] MeanBias   = 19'd393216;
  localparam logic [18:0] MeanRecip  = 19'd349526;
  localparam logic [18:0] MeanOffset = 19'd131072;

  function automatic logic signed [17:0] rot_cos(input logic [2:0] sec);
    logic signed [17:0] r;
    case (sec)
      3'd1: r = 18'sd56756;
      3'd2: r = 18'sd56756;
      3'd3: r = 18'sd2;
      3'd4: r = -18'sd56754;
      3'd5: r = -18'sd56758;
      default: r = 18'sd2;
    endcase
    return r;
  endfunction

  function automatic logic signed [17:0] rot_sin(input logic [2:0] sec);
    logic signed [17:0] r;
    case (sec)
      3'd1: r = -18'sd32768;
      3'd2: r = 18'sd32768;
      3'd3: r = 18'sd65536;
      3'd4: r = 18'sd32770;
      3'd5: r = -18'sd32765;
      default: r = -18'sd65536;
    endcase
    return r;
  endfunction

  function automatic logic signed [14:0] sat15(input logic signed [19:0] v);
    logic signed [14:0] r;
    if (v > 20'sd16383) begin
      r = 15'sd16383;
    end else if (v < -20'sd16384) begin
      r = -15'sd16384;
    end else begin
      r = v[14:0];
    end
    return r;
  endfunction

  function automatic logic signed [13:0] sat14(input logic signed [19:0] v);
    logic signed [13:0] r;
    if (v > 20'sd8191) begin
      r = 14'sd8191;
    end else if (v < -20'sd8192) begin
      r = -14'sd8192;
    end else begin
      r = v[13:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sph_geom.sv
`default_nettype none

module sph_geom (
  input  logic                clk_i,
  input  sph_pkg::stage_en_t  en_i,
  input  logic [8:0]          u_pos_i,
  input  logic [8:0]          v_pos_i,
  input  logic [8:0]          w_pos_i,
  output sph_pkg::cross_t     x_uv_o,
  output sph_pkg::cross_t     x_uw_o,
  output sph_pkg::cross_t     x_vw_o,
  output sph_pkg::cross_t     y_uv_o,
  output sph_pkg::cross_t     y_vw_o,
  output logic signed [12:0]  dal_o
);

  // stage 1: side distances and dalitz partial products
  logic [25:0] du1_q, dv1_q, dw1_q;
  logic [30:0] pu1_q;
  logic [31:0] pvw1_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      du1_q  <= {17'd0, u_pos_i} * 26'(sph_pkg::KU);
      dv1_q  <= {17'd0, v_pos_i} * 26'(sph_pkg::KV);
      dw1_q  <= {17'd0, w_pos_i} * 26'(sph_pkg::KW);
      pu1_q  <= {22'd0, u_pos_i} * 31'(sph_pkg::DalU);
      pvw1_q <= ({23'd0, v_pos_i} + {23'd0, w_pos_i}) * 32'(sph_pkg::DalVw);
    end
  end

  // stage 2: first constant products, rounded back to q16
  logic signed [26:0] a2;
  logic signed [43:0] p_a2, p_y2, p_wl2;
  logic signed [44:0] p_uc2;
  logic signed [43:0] r_a2, r_y2, r_wl2;
  logic signed [44:0] r_uc2;
  logic [32:0]        dsum2;
  logic [12:0]        dal2;

  always_comb begin
    a2    = 27'(sph_pkg::SideU) - $signed({1'b0, du1_q});
    p_a2  = 44'(a2) * 44'(sph_pkg::CosBase);
    p_y2  = 44'($signed({1'b0, du1_q})) * 44'(sph_pkg::SinBase);
    p_wl2 = 44'($signed({1'b0, dw1_q})) * 44'(sph_pkg::RatioVw);
    p_uc2 = 45'($signed({1'b0, dv1_q})) * 45'(sph_pkg::RatioUv);
    r_a2  = p_a2 + 44'sd32768;
    r_y2  = p_y2 + 44'sd32768;
    r_wl2 = p_wl2 + 44'sd32768;
    r_uc2 = p_uc2 + 45'sd32768;
    dsum2 = {2'd0, pu1_q} + {1'b0, pvw1_q} + 33'd524288;
    dal2  = dsum2[32:20] - sph_pkg::DalBase;
  end

  logic signed [27:0] m_cos_a2_q, y_uv2_q, m_wl2_q;
  logic signed [28:0] m_uc2_q;
  logic [25:0]        dv2_q, dw2_q;
  logic signed [12:0] dal2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      m_cos_a2_q <= r_a2[43:16];
      y_uv2_q    <= r_y2[43:16];
      m_wl2_q    <= r_wl2[43:16];
      m_uc2_q    <= r_uc2[44:16];
      dv2_q      <= dv1_q;
      dw2_q      <= dw1_q;
      dal2_q     <= dal2;
    end
  end

  // stage 3: uv and uw crossings, corrected u side for the vw crossing
  logic signed [28:0] dv3, dw3;
  logic signed [28:0] x_uv3, x_uw3, uc3, b3;

  always_comb begin
    dv3   = $signed({3'd0, dv2_q});
    dw3   = $signed({3'd0, dw2_q});
    x_uv3 = 29'(sph_pkg::ApexX) - dv3 + 29'(m_cos_a2_q);
    x_uw3 = 29'(sph_pkg::ApexSideV) + 29'(m_wl2_q) - 29'(m_cos_a2_q);
    uc3   = 29'(sph_pkg::TwoSideU) - m_uc2_q - dw3;
    b3    = m_uc2_q + dw3 - 29'(sph_pkg::SideU);
  end

  logic signed [28:0] x_uv3_q, x_uw3_q, uc3_q, b3_q;
  logic signed [27:0] y_uv3_q, m_wl3_q;
  logic signed [12:0] dal3_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      x_uv3_q <= x_uv3;
      x_uw3_q <= x_uw3;
      uc3_q   <= uc3;
      b3_q    <= b3;
      y_uv3_q <= y_uv2_q;
      m_wl3_q <= m_wl2_q;
      dal3_q  <= dal2_q;
    end
  end

  // stage 4: vw crossing products
  logic signed [45:0] p_b4, p_y4, r_b4, r_y4;

  always_comb begin
    p_b4 = 46'(b3_q) * 46'(sph_pkg::CosBase);
    p_y4 = 46'(uc3_q) * 46'(sph_pkg::SinBase);
    r_b4 = p_b4 + 46'sd32768;
    r_y4 = p_y4 + 46'sd32768;
  end

  logic signed [29:0] m_cos_b4_q, y_vw4_q;
  logic signed [28:0] x_uv4_q, x_uw4_q;
  logic signed [27:0] y_uv4_q, m_wl4_q;
  logic signed [12:0] dal4_q;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      m_cos_b4_q <= r_b4[45:16];
      y_vw4_q    <= r_y4[45:16];
      x_uv4_q    <= x_uv3_q;
      x_uw4_q    <= x_uw3_q;
      y_uv4_q    <= y_uv3_q;
      m_wl4_q    <= m_wl3_q;
      dal4_q     <= dal3_q;
    end
  end

  // stage 5: vw crossing x
  logic signed [29:0] x_vw5;

  always_comb begin
    x_vw5 = 30'(sph_pkg::ApexSideV) - m_cos_b4_q + 30'(m_wl4_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      x_uv_o <= x_uv4_q[27:0];
      x_uw_o <= x_uw4_q[27:0];
      x_vw_o <= x_vw5[27:0];
      y_uv_o <= y_uv4_q;
      y_vw_o <= y_vw4_q[27:0];
      dal_o  <= dal4_q;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sph_mean.sv
`default_nettype none

module sph_mean (
  input  logic                clk_i,
  input  sph_pkg::stage_en_t  en_i,
  input  sph_pkg::cross_t     a_i,
  input  sph_pkg::cross_t     b_i,
  input  sph_pkg::cross_t     c_i,
  output logic signed [13:0]  mean_o
);

  // stage 6: sum and divide by 4096
  logic signed [29:0] sum6;
  logic signed [17:0] q6_q;

  always_comb begin
    sum6 = 30'(a_i) + 30'(b_i) + 30'(c_i) + 30'sd6144;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      q6_q <= sum6[29:12];
    end
  end

  // stage 7: biased reciprocal product for the divide by 3
  logic [18:0] n7;
  logic [37:0] prod7_q;

  always_comb begin
    n7 = {q6_q[17], q6_q} + sph_pkg::MeanBias;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      prod7_q <= 38'(n7) * 38'(sph_pkg::MeanRecip);
    end
  end

  // stage 8: remove bias
  logic signed [18:0] r8_q;

  always_ff @(posedge clk_i) begin
    if (en_i[8]) begin
      r8_q <= {1'b0, prod7_q[37:20]} - sph_pkg::MeanOffset;
    end
  end

  // stage 9: clamp to field range
  always_ff @(posedge clk_i) begin
    if (en_i[9]) begin
      mean_o <= sph_pkg::sat14(20'(r8_q));
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sph_hall.sv
`default_nettype none

module sph_hall (
  input  logic                clk_i,
  input  sph_pkg::stage_en_t  en_i,
  input  logic [2:0]          sector_i,
  input  sph_pkg::cross_t     x_i,
  input  sph_pkg::cross_t     y_i,
  output logic signed [14:0]  hall_x_o,
  output logic signed [14:0]  hall_y_o,
  output logic signed [14:0]  hall_z_o
);

  // stage 6: offset along the tilted face
  sph_pkg::cross_t    x6_q;
  logic signed [28:0] t6_q;

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      x6_q <= x_i;
      t6_q <= 29'(y_i) + 29'(sph_pkg::OffY);
    end
  end

  // stage 7: tilt
  logic signed [45:0] p_c7, p_s7, r_c7, r_s7;

  always_comb begin
    p_c7 = 46'(t6_q) * 46'(sph_pkg::CosTilt);
    p_s7 = 46'(t6_q) * 46'(sph_pkg::SinTilt);
    r_c7 = p_c7 + 46'sd32768;
    r_s7 = p_s7 + 46'sd32768;
  end

  sph_pkg::cross_t    x7_q;
  logic signed [28:0] yl7_q, zm7_q;

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      x7_q  <= x6_q;
      yl7_q <= r_c7[44:16];
      zm7_q <= r_s7[44:16];
    end
  end

  // stage 8: sector rotation products, z rounding
  logic signed [17:0] rc8, rs8;
  logic signed [29:0] zl8, zr8;

  always_comb begin
    rc8 = sph_pkg::rot_cos(sector_i);
    rs8 = sph_pkg::rot_sin(sector_i);
    zl8 = 30'(sph_pkg::OffZ) - 30'(zm7_q);
    zr8 = zl8 + 30'sd2048;
  end

  logic signed [47:0] pxc8_q, pxs8_q, pyc8_q, pys8_q;
  logic signed [17:0] hz8_q;

  always_ff @(posedge clk_i) begin
    if (en_i[8]) begin
      pxc8_q <= 48'(x7_q) * 48'(rc8);
      pxs8_q <= 48'(x7_q) * 48'(rs8);
      pyc8_q <= 48'(yl7_q) * 48'(rc8);
      pys8_q <= 48'(yl7_q) * 48'(rs8);
      hz8_q  <= zr8[29:12];
    end
  end

  // stage 9: combine, round to sixteenths, clamp
  logic signed [47:0] hx9, hy9;

  always_comb begin
    hx9 = pxc8_q - pys8_q + 48'sd134217728;
    hy9 = pxs8_q + pyc8_q + 48'sd134217728;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[9]) begin
      hall_x_o <= sph_pkg::sat15(hx9[47:28]);
      hall_y_o <= sph_pkg::sat15(hy9[47:28]);
      hall_z_o <= sph_pkg::sat15(20'(hz8_q));
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/strip_peak_to_hall_coordinates.sv
// Converts the U, V and W strip peak positions of one calorimeter cluster
// into the mean local x/y of the three view crossings, the Dalitz sum, and
// the hall x/y/z of the UV, UW and VW crossings.
// Input channel: in_valid_i / in_stall_o with u_pos_i, v_pos_i, w_pos_i.
// Output channel: out_valid_o / out_stall_i with all result fields.
// A request moves when valid is high and stall is low at a rising edge.
// Sector: cfg_we_i writes cfg_wdata_i; values above 5 are dropped. Write it
// only while the pipeline is empty.
// Results pass through the nine register stages of the constant-product and
// rotation chain between acceptance and out_valid_o.
// Throughput: one request per cycle while in_stall_o is low, one result per request.
// Reset empties the pipeline and sets sector to 0.
// When the receiver stalls, the output holds; upstream stages keep filling
// empty slots, and in_stall_o rises only once every stage holds a request.
`default_nettype none

module strip_peak_to_hall_coordinates (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [8:0]         u_pos_i,
  input  logic [8:0]         v_pos_i,
  input  logic [8:0]         w_pos_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [13:0] local_x_o,
  output logic signed [13:0] local_y_o,
  output logic signed [12:0] dalitz_sum_o,
  output logic signed [14:0] uv_hall_x_o,
  output logic signed [14:0] uv_hall_y_o,
  output logic signed [14:0] uv_hall_z_o,
  output logic signed [14:0] uw_hall_x_o,
  output logic signed [14:0] uw_hall_y_o,
  output logic signed [14:0] uw_hall_z_o,
  output logic signed [14:0] vw_hall_x_o,
  output logic signed [14:0] vw_hall_y_o,
  output logic signed [14:0] vw_hall_z_o
);

  logic [2:0]         sector_q;
  sph_pkg::stage_en_t en;
  sph_pkg::stage_en_t valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sector_q <= 3'd0;
    end else if (cfg_we_i && (cfg_wdata_i <= sph_pkg::SectorMax)) begin
      sector_q <= cfg_wdata_i;
    end
  end

  // a stage loads when it is empty or its contents move on
  always_comb begin
    en[sph_pkg::LastStage] = !valid_q[sph_pkg::LastStage] || !out_stall_i;
    for (int k = sph_pkg::LastStage - 1; k >= 1; k--) begin
      en[k] = !valid_q[k] || en[k + 1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[1]) begin
        valid_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= sph_pkg::LastStage; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k - 1];
        end
      end
    end
  end

  assign in_stall_o  = !en[1];
  assign out_valid_o = valid_q[sph_pkg::LastStage];

  sph_pkg::cross_t    x_uv, x_uw, x_vw, y_uv, y_vw;
  logic signed [12:0] dal5;

  sph_geom u_geom (
    .clk_i   (clk_i),
    .en_i    (en),
    .u_pos_i (u_pos_i),
    .v_pos_i (v_pos_i),
    .w_pos_i (w_pos_i),
    .x_uv_o  (x_uv),
    .x_uw_o  (x_uw),
    .x_vw_o  (x_vw),
    .y_uv_o  (y_uv),
    .y_vw_o  (y_vw),
    .dal_o   (dal5)
  );

  // dalitz sum rides along stages 6 to 9
  logic signed [12:0] dal6_q, dal7_q, dal8_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      dal6_q <= dal5;
    end
    if (en[7]) begin
      dal7_q <= dal6_q;
    end
    if (en[8]) begin
      dal8_q <= dal7_q;
    end
    if (en[9]) begin
      dalitz_sum_o <= dal8_q;
    end
  end

  sph_mean u_mean_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (x_uv),
    .b_i    (x_uw),
    .c_i    (x_vw),
    .mean_o (local_x_o)
  );

  sph_mean u_mean_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (y_uv),
    .b_i    (y_uv),
    .c_i    (y_vw),
    .mean_o (local_y_o)
  );

  sph_hall u_hall_uv (
    .clk_i    (clk_i),
    .en_i     (en),
    .sector_i (sector_q),
    .x_i      (x_uv),
    .y_i      (y_uv),
    .hall_x_o (uv_hall_x_o),
    .hall_y_o (uv_hall_y_o),
    .hall_z_o (uv_hall_z_o)
  );

  sph_hall u_hall_uw (
    .clk_i    (clk_i),
    .en_i     (en),
    .sector_i (sector_q),
    .x_i      (x_uw),
    .y_i      (y_uv),
    .hall_x_o (uw_hall_x_o),
    .hall_y_o (uw_hall_y_o),
    .hall_z_o (uw_hall_z_o)
  );

  sph_hall u_hall_vw (
    .clk_i    (clk_i),
    .en_i     (en),
    .sector_i (sector_q),
    .x_i      (x_vw),
    .y_i      (y_vw),
    .hall_x_o (vw_hall_x_o),
    .hall_y_o (vw_hall_y_o),
    .hall_z_o (vw_hall_z_o)
  );

endmodule

`default_nettype wire
